// ===== sv/els_pkg.sv =====
// ----------------------------------------------------------------------------
// els_pkg
// Shared types, codes and constants of the electronic load setpoint core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package els_pkg;

  localparam logic [1:0] FUNC_CC     = 2'd0;
  localparam logic [1:0] FUNC_CR     = 2'd1;
  localparam logic [1:0] FUNC_CP     = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] CFG_ARMED = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_GAIN  = 2'd2;

  localparam logic [15:0] LIMIT_RESET = 16'd5000;
  localparam logic [31:0] GAIN_RESET  = 32'd65536;
  localparam logic [30:0] SET_MAX     = 31'h7FFF_FFFF;

  // numerator width of every divider: setpoint (31 bits) times 1000
  localparam int DIV_NW     = 41;
  localparam int QUEUE_DEPTH = 2;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_1000  = 32'h1062_4DD3;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] set;
    logic [15:0] volt;
    logic [15:0] imeas;
    logic        zero_div;
  } els_item_t;

  typedef struct packed {
    logic        armed;
    logic [15:0] limit;
    logic [31:0] gain;
  } els_cfg_t;

endpackage

// ===== sv/els_if.sv =====
// ----------------------------------------------------------------------------
// els_if
// Request, result and configuration channels of the setpoint core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface els_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic signed [31:0] set_value;
  logic        [15:0] volt_mv;
  logic        [15:0] meas_current_ma;
  modport source (output valid, func, set_value, volt_mv, meas_current_ma, input ready);
  modport sink   (input valid, func, set_value, volt_mv, meas_current_ma, output ready);
endinterface

interface els_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dac_mv;
  logic        limit_hit;
  logic [30:0] applied_setpoint;
  logic [31:0] power_mw;
  logic [31:0] resistance_mohm;
  logic        resistance_open;
  modport source (output valid, dac_mv, limit_hit, applied_setpoint, power_mw,
                  resistance_mohm, resistance_open, input ready);
  modport sink   (input valid, dac_mv, limit_hit, applied_setpoint, power_mw,
                  resistance_mohm, resistance_open, output ready);
endinterface

interface els_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/els_front.sv =====
// ----------------------------------------------------------------------------
// els_front
// Accepts requests, drops negative setpoints and unused codes, flags zero
// divisors and hands valid items to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module els_front
  import els_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  els_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output els_item_t q_item
);

  logic      fr_valid_r, fr_valid_nxt;
  els_item_t fr_item_r;
  logic      accept, keep, zd;

  assign q_push      = fr_valid_r && !q_full;
  assign q_item      = fr_item_r;
  assign in_ch.ready = !fr_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    keep = !in_ch.set_value[31] && (in_ch.func != FUNC_UNUSED);
    case (in_ch.func)
      FUNC_CR: zd = (in_ch.set_value[30:0] == '0);
      FUNC_CP: zd = (in_ch.volt_mv == '0);
      default: zd = 1'b0;
    endcase
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = keep;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.func     <= in_ch.func;
      fr_item_r.set      <= in_ch.set_value[30:0];
      fr_item_r.volt     <= in_ch.volt_mv;
      fr_item_r.imeas    <= in_ch.meas_current_ma;
      fr_item_r.zero_div <= zd;
    end
  end

endmodule

// ===== sv/els_queue.sv =====
// ----------------------------------------------------------------------------
// els_queue
// Short FIFO between the front and the back pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module els_queue
  import els_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  els_item_t push_item,
  output logic      full,
  input  logic      pop,
  output els_item_t pop_item,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  els_item_t        mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== sv/els_div.sv =====
// ----------------------------------------------------------------------------
// els_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module els_div
  import els_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];

  assign quo = nq_r[NW-1];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_i, den_i;
    logic [NW-1:0] nq_i;
    logic [DW:0]   t, diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign nq_i  = num;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign nq_i  = nq_r[s-1];
      assign den_i = den_r[s-1];
    end

    always_comb begin
      t    = {rem_i, nq_i[NW-1]};
      diff = t - {1'b0, den_i};
      ge   = (t >= {1'b0, den_i});
    end

    // shift the numerator out and the quotient bit in
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nq_r[s]  <= {nq_i[NW-2:0], ge};
        den_r[s] <= den_i;
      end
    end
  end

endmodule

// ===== sv/els_back.sv =====
// ----------------------------------------------------------------------------
// els_back
// Products, dividers, clamp, setpoint rewrite and DAC scaling; the last
// stage is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module els_back
  import els_pkg::*;
#(
  parameter int NW = DIV_NW
) (
  input  logic      clk,
  input  logic      rst_n,
  input  els_cfg_t  cfg,
  input  logic      q_empty,
  input  els_item_t q_item,
  output logic      q_pop,
  els_out_if.source out_ch
);

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] set;
    logic        zero_div;
    logic        imeas_zero;
  } side_t;

  logic en;

  // product stage
  logic          p_valid_r;
  side_t         p_side_r;
  logic [NW-1:0] p_num_t_r;
  logic [30:0]   p_den_t_r;
  logic [25:0]   p_volt1k_r;
  logic [31:0]   p_pw_r, p_cp_r;
  logic [15:0]   p_imeas_r;

  // divide by 1000 through the reciprocal
  logic [63:0]   pw_prod, cp_prod;

  // divider stages
  logic          v_r    [NW];
  side_t         side_r [NW];
  logic [25:0]   pwq_r  [NW];
  logic [25:0]   cpq_r  [NW];
  logic [NW-1:0] tq, crq, rq;

  // clamp stage
  logic          c_valid_r, c_clamp_r, c_open_r;
  logic [15:0]   c_target_r;
  logic [30:0]   c_applied_r;
  logic [31:0]   c_power_r, c_res_r;
  logic          clamp;
  logic [30:0]   applied;

  // output stage
  logic          d_valid_r;
  logic [47:0]   prod;
  logic [15:0]   dac;

  assign en    = !d_valid_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (en) begin
      p_side_r.func       <= q_item.func;
      p_side_r.set        <= q_item.set;
      p_side_r.zero_div   <= q_item.zero_div;
      p_side_r.imeas_zero <= (q_item.imeas == '0);
      p_volt1k_r          <= 26'(q_item.volt) * 26'd1000;
      p_pw_r              <= 32'(q_item.imeas) * 32'(q_item.volt);
      p_cp_r              <= 32'(q_item.volt) * 32'(cfg.limit);
      p_imeas_r           <= q_item.imeas;
      unique case (q_item.func)
        FUNC_CR: begin
          p_num_t_r <= NW'(q_item.volt) * NW'(1000);
          p_den_t_r <= q_item.set;
        end
        FUNC_CP: begin
          p_num_t_r <= NW'(q_item.set) * NW'(1000);
          p_den_t_r <= 31'(q_item.volt);
        end
        default: begin
          // constant current passes through a divide by one
          p_num_t_r <= NW'(q_item.set);
          p_den_t_r <= 31'd1;
        end
      endcase
    end
  end

  els_div #(.NW(NW), .DW(31)) u_div_target (
    .clk(clk), .en(en), .num(p_num_t_r), .den(p_den_t_r), .quo(tq));
  els_div #(.NW(NW), .DW(16)) u_div_cr (
    .clk(clk), .en(en), .num(NW'(p_volt1k_r)), .den(cfg.limit), .quo(crq));
  els_div #(.NW(NW), .DW(16)) u_div_res (
    .clk(clk), .en(en), .num(NW'(p_volt1k_r)), .den(p_imeas_r), .quo(rq));

  assign pw_prod = 64'(p_pw_r) * 64'(RECIP_1000);
  assign cp_prod = 64'(p_cp_r) * 64'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= p_side_r;
      pwq_r[0]  <= 26'(pw_prod >> RECIP_SHIFT);
      cpq_r[0]  <= 26'(cp_prod >> RECIP_SHIFT);
      for (int i = 1; i < NW; i++) begin
        side_r[i] <= side_r[i-1];
        pwq_r[i]  <= pwq_r[i-1];
        cpq_r[i]  <= cpq_r[i-1];
      end
    end
  end

  always_comb begin
    clamp = side_r[NW-1].zero_div || (tq >= NW'(cfg.limit));
    case (side_r[NW-1].func)
      FUNC_CR: applied = !clamp ? side_r[NW-1].set :
                         (cfg.limit == '0) ? SET_MAX : 31'(crq);
      FUNC_CP: applied = clamp ? 31'(cpq_r[NW-1]) : side_r[NW-1].set;
      default: applied = clamp ? 31'(cfg.limit) : side_r[NW-1].set;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_clamp_r   <= clamp;
      c_target_r  <= clamp ? cfg.limit : tq[15:0];
      c_applied_r <= applied;
      c_power_r   <= 32'(pwq_r[NW-1]);
      c_open_r    <= side_r[NW-1].imeas_zero;
      c_res_r     <= side_r[NW-1].imeas_zero ? 32'hFFFF_FFFF : rq[31:0];
    end
  end

  always_comb begin
    prod = 48'(c_target_r) * 48'(cfg.gain);
    if (!cfg.armed) begin
      dac = '0;
    end else if (prod[47:32] != '0) begin
      dac = 16'hFFFF;
    end else begin
      dac = prod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.dac_mv           <= dac;
      out_ch.limit_hit        <= c_clamp_r;
      out_ch.applied_setpoint <= c_applied_r;
      out_ch.power_mw         <= c_power_r;
      out_ch.resistance_mohm  <= c_res_r;
      out_ch.resistance_open  <= c_open_r;
    end
  end

  // valid travels with the data; advance all stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      for (int i = 0; i < NW; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      p_valid_r <= !q_empty;
      v_r[0]    <= p_valid_r;
      for (int i = 1; i < NW; i++) begin
        v_r[i] <= v_r[i-1];
      end
      c_valid_r <= v_r[NW-1];
      d_valid_r <= c_valid_r;
    end
  end

  assign out_ch.valid = d_valid_r;

  a_clamp_target: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && c_clamp_r) |-> (c_target_r == cfg.limit))
    else $error("clamped target differs from limit");

  a_unclamped_below: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && !c_clamp_r) |-> (c_target_r < cfg.limit))
    else $error("unclamped target not below limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !out_ch.ready) |=>
      ((c_target_r === $past(c_target_r)) && c_valid_r == $past(c_valid_r)))
    else $error("pipeline moved during stall");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

// ===== sv/electronic_load_setpoint_core.sv =====
// ----------------------------------------------------------------------------
// electronic_load_setpoint_core
// CC / CR / CP setpoint engine with current clamp, DAC scaling and
// measured power and resistance.
// ----------------------------------------------------------------------------
// One request enters per clock and one result leaves per clock when the
// result side keeps ready high. Requests pass the 41-stage bit-per-cycle
// dividers between the product and clamp stages; a two-entry queue
// separates the input register from the pipeline so each side can stall
// alone. Requests with a negative setpoint or the unused function code are
// dropped without a result. Configuration writes are taken at any time,
// but must only be made while no request is in flight.
`timescale 1ns / 1ps

module electronic_load_setpoint_core
  import els_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH,
  parameter int NW     = DIV_NW
) (
  input  logic       clk,
  input  logic       rst_n,
  els_in_if.sink     in_ch,
  els_out_if.source  out_ch,
  els_cfg_if.sink    cfg_ch
);

  els_cfg_t  cfg_r;
  logic      q_push, q_pop, q_full, q_empty;
  els_item_t push_item, pop_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.armed <= 1'b0;
      cfg_r.limit <= LIMIT_RESET;
      cfg_r.gain  <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ARMED: cfg_r.armed <= cfg_ch.data[0];
        CFG_LIMIT: cfg_r.limit <= cfg_ch.data[15:0];
        CFG_GAIN:  cfg_r.gain  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  els_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_full(q_full), .q_push(q_push), .q_item(push_item));

  els_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(push_item),
    .full(q_full), .pop(q_pop), .pop_item(pop_item), .empty(q_empty));

  els_back #(.NW(NW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty),
    .q_item(pop_item), .q_pop(q_pop), .out_ch(out_ch));

endmodule
